/* rtl/core/crossfade_delay_pitch_shifter_defines.svh */
// ============================================================================
// Crossfade delay pitch shifter: assertion macros
// Immediate-consequence and next-cycle property wrappers on clk / rst.
// ============================================================================
`ifndef CROSSFADE_DELAY_PITCH_SHIFTER_DEFINES_SVH
`define CROSSFADE_DELAY_PITCH_SHIFTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define CDPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CDPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cdps_pkg.sv */
// ============================================================================
// cdps_pkg
// Shared types and fixed constants of the crossfade delay pitch shifter.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package cdps_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RATIO_W  = 10;

  localparam logic [RATIO_W-1:0] RATIO_UNITY = 10'd256;
  localparam logic [RATIO_W-1:0] RATIO_RESET = 10'd499;

  // High-pass filter datapath widths
  localparam int HP_HIST_W = 24;
  localparam int HP_PROD_W = 56;
  localparam int HP_ACC_W  = 58;

  // 300 Hz high-pass, Q2.28; feedback terms stored negated
  localparam logic signed [31:0] HP_A0  = 32'sd264415412;
  localparam logic signed [31:0] HP_A1  = -32'sd528830825;
  localparam logic signed [31:0] HP_A2  = 32'sd264415412;
  localparam logic signed [31:0] HP_NB1 = 32'sd528770618;
  localparam logic signed [31:0] HP_NB2 = -32'sd260455576;

  localparam logic signed [HP_ACC_W-1:0] HP_RND = 58'sd134217728;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    valid;
    sample_t sample;
  } cdps_hp_res_t;

  typedef struct packed {
    logic    valid;
    sample_t tap_a;
    sample_t tap_b;
  } cdps_taps_t;

endpackage

`default_nettype wire

/* rtl/core/cdps_in_if.sv */
// ============================================================================
// cdps_in_if
// Input sample stream: valid / ready handshake with one sample per transfer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface cdps_in_if import cdps_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

/* rtl/core/cdps_out_if.sv */
// ============================================================================
// cdps_out_if
// Output sample stream: valid / ready handshake with one sample per transfer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface cdps_out_if import cdps_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

/* rtl/core/cdps_hpf.sv */
// ============================================================================
// cdps_hpf
// Biquad high-pass: five parallel products, two adder stages, round/saturate.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cdps_hpf import cdps_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  sample_t      x_in,
  output cdps_hp_res_t res
);

  logic v0, v1, v2, v3;

  sample_t                      x_cur, x1, x2;
  logic signed [HP_HIST_W-1:0]  y1, y2;
  logic signed [HP_PROD_W-1:0]  p0, p1, p2, p3, p4;
  logic signed [HP_ACC_W-1:0]   s_ff, s_fb, acc;

  logic signed [HP_HIST_W-1:0]  x0s, x1s, x2s;
  logic signed [HP_ACC_W-1:0]   acc_rnd;
  logic        [29:0]           t30;
  logic signed [HP_HIST_W-1:0]  y_sat;
  logic        [HP_HIST_W:0]    u25;
  logic        [16:0]           h17;
  sample_t                      h_sat;

  assign x0s = {x_cur, 8'h00};
  assign x1s = {x1, 8'h00};
  assign x2s = {x2, 8'h00};

  // Round to Q1.23 and saturate, then round to Q1.15 and saturate
  always_comb begin
    acc_rnd = acc + HP_RND;
    t30     = acc_rnd[HP_ACC_W-1:28];
    if (t30[29:23] != {7{t30[29]}}) begin
      y_sat = t30[29] ? 24'sh800000 : 24'sh7FFFFF;
    end else begin
      y_sat = t30[23:0];
    end
    u25 = {y_sat[HP_HIST_W-1], y_sat} + 25'd128;
    h17 = u25[24:8];
    if (h17[16] != h17[15]) begin
      h_sat = h17[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      h_sat = h17[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      res <= '0;
      x1  <= '0;
      x2  <= '0;
      y1  <= '0;
      y2  <= '0;
    end else begin
      v0        <= start;
      v1        <= v0;
      v2        <= v1;
      v3        <= v2;
      res.valid <= v3;
      if (v0) begin
        x1 <= x_cur;
        x2 <= x1;
      end
      if (v3) begin
        res.sample <= h_sat;
        y1         <= y_sat;
        y2         <= y1;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (start) begin
      x_cur <= x_in;
    end
    if (v0) begin
      p0 <= HP_A0 * x0s;
      p1 <= HP_A1 * x1s;
      p2 <= HP_A2 * x2s;
      p3 <= HP_NB1 * y1;
      p4 <= HP_NB2 * y2;
    end
    if (v1) begin
      s_ff <= HP_ACC_W'(p0) + HP_ACC_W'(p1) + HP_ACC_W'(p2);
      s_fb <= HP_ACC_W'(p3) + HP_ACC_W'(p4);
    end
    if (v2) begin
      acc <= s_ff + s_fb;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cdps_ring.sv */
// ============================================================================
// cdps_ring
// Ring memory with clearing pass, pointer / crossfade state and access
// sequencer: one write and two tap reads per sample on a single port.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cdps_ring import cdps_pkg::*; #(
  parameter int BUF_DEPTH   = 1000,
  parameter int OVERLAP_LEN = 100
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [RATIO_W-1:0]                 shift_ratio,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cdps_hp_res_t                       hp_res,
  input  logic                               mix_ready,
  output cdps_taps_t                         taps,
  output logic [$clog2(OVERLAP_LEN+1)-1:0]   weight
);

  localparam int AW   = $clog2(BUF_DEPTH);
  localparam int RPW  = $clog2(BUF_DEPTH * 256 + 1024);
  localparam int RIW  = RPW - 7;
  localparam int WW   = $clog2(OVERLAP_LEN + 1);
  localparam int DIFW = ((AW > WW) ? AW : WW) + 2;
  localparam int HALF = BUF_DEPTH / 2;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_FILT   = 3'd2;
  localparam logic [2:0] ST_RDA    = 3'd3;
  localparam logic [2:0] ST_RDB    = 3'd4;
  localparam logic [2:0] ST_LAUNCH = 3'd5;

  logic [2:0]     state, state_next;
  logic [AW-1:0]  clr_cnt;
  logic [AW-1:0]  wp;
  logic [RPW-1:0] rp;
  logic [WW-1:0]  fade;

  logic [AW-1:0]  idx_a, idx_b, wr_addr;
  sample_t        tap_a;

  sample_t        mem [BUF_DEPTH];
  sample_t        rd_data;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_addr;
  sample_t        mem_wdata;

  logic [RIW-1:0]         ri_cur, ri_sum;
  logic [AW-1:0]          ia, ib;
  logic [AW:0]            ia_ext, ib_ext;
  logic signed [DIFW-1:0] da, db;
  logic                   moving, near_a, near_b;
  logic [WW-1:0]          w_mid, w_new;
  logic [RPW-1:0]         rp_sum, rp_next;
  logic [AW-1:0]          wp_next;
  logic                   take;

  function automatic logic [RIW-1:0] round_idx(input logic [RPW-1:0] pos);
    logic [RPW:0] s;
    s = {1'b0, pos} + (RPW+1)'(128);
    return RIW'(s >> 8);
  endfunction

  // Tap indices, crossfade weight and pointer advance for the next sample
  always_comb begin
    ri_cur = round_idx(rp);
    ia     = (ri_cur >= RIW'(BUF_DEPTH)) ? '0 : ri_cur[AW-1:0];
    ia_ext = {1'b0, ia};
    ib_ext = (ia >= AW'(HALF)) ? ia_ext - (AW+1)'(HALF) : ia_ext + (AW+1)'(HALF);
    ib     = (ib_ext >= (AW+1)'(BUF_DEPTH)) ? AW'(BUF_DEPTH - 1) : ib_ext[AW-1:0];

    da     = $signed(DIFW'(wp)) - $signed(DIFW'(ia));
    db     = $signed(DIFW'(wp)) - $signed(DIFW'(ib));
    moving = (shift_ratio != RATIO_UNITY);
    near_a = !da[DIFW-1] && (da <= $signed(DIFW'(OVERLAP_LEN)));
    near_b = !db[DIFW-1] && (db <= $signed(DIFW'(OVERLAP_LEN)));

    if (moving && near_a) begin
      w_mid = da[WW-1:0];
    end else if (da == '0) begin
      w_mid = '0;
    end else begin
      w_mid = fade;
    end
    if (moving && near_b) begin
      w_new = WW'(OVERLAP_LEN) - db[WW-1:0];
    end else if (db == '0) begin
      w_new = WW'(OVERLAP_LEN);
    end else begin
      w_new = w_mid;
    end

    rp_sum  = rp + RPW'(shift_ratio);
    ri_sum  = round_idx(rp_sum);
    rp_next = (ri_sum >= RIW'(BUF_DEPTH)) ? '0 : rp_sum;
    wp_next = (wp == AW'(BUF_DEPTH - 1)) ? '0 : wp + 1'b1;
  end

  assign in_ready = (state == ST_IDLE);
  assign take     = in_valid && in_ready;

  // Single memory port: clear, write filtered sample, read tap A, read tap B
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = wr_addr;
    mem_wdata = hp_res.sample;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      ST_FILT: begin
        mem_we = hp_res.valid;
      end
      ST_RDA: begin
        mem_re   = 1'b1;
        mem_addr = idx_a;
      end
      ST_RDB: begin
        mem_re   = 1'b1;
        mem_addr = idx_b;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_cnt == AW'(BUF_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (take) state_next = ST_FILT;
      ST_FILT:   if (hp_res.valid) state_next = ST_RDA;
      ST_RDA:    state_next = ST_RDB;
      ST_RDB:    state_next = ST_LAUNCH;
      ST_LAUNCH: if (mix_ready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      wp      <= '0;
      rp      <= '0;
      fade    <= WW'(OVERLAP_LEN);
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (take) begin
        wp   <= wp_next;
        rp   <= rp_next;
        fade <= w_new;
      end
    end
  end

  // Hold the addresses of this sample and capture tap A
  always_ff @(posedge clk) begin
    if (take) begin
      idx_a   <= ia;
      idx_b   <= ib;
      wr_addr <= wp;
    end
    if (state == ST_RDB) begin
      tap_a <= rd_data;
    end
  end

  assign taps.valid = (state == ST_LAUNCH);
  assign taps.tap_a = tap_a;
  assign taps.tap_b = rd_data;
  assign weight     = fade;

endmodule

`default_nettype wire

/* rtl/core/cdps_mix.sv */
// ============================================================================
// cdps_mix
// Weighted two-tap mix, division by the overlap length through a reciprocal
// multiply, and the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module cdps_mix import cdps_pkg::*; #(
  parameter int OVERLAP_LEN = 100
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cdps_taps_t                        taps,
  input  logic [$clog2(OVERLAP_LEN+1)-1:0]  weight,
  output logic                              ready,
  cdps_out_if.source                        dout
);

  localparam int WW    = $clog2(OVERLAP_LEN + 1);
  localparam int NW    = SAMPLE_W + 1 + WW;
  localparam int MW    = SAMPLE_W - 1 + WW;
  localparam int SHIFT = MW + $clog2(OVERLAP_LEN);
  localparam int RW    = MW + 2;
  localparam int PW    = MW + RW;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(OVERLAP_LEN) - 64'd1) / 64'(OVERLAP_LEN);
  localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

  logic v1, v2, v3, out_valid;

  sample_t              a_q, b_q, out_data;
  logic [WW-1:0]        w_q;
  logic signed [NW-1:0] num, num_next;
  logic [NW-1:0]        mag_full;
  logic [PW-1:0]        qprod;
  logic                 neg;
  logic [SAMPLE_W-1:0]  q;
  logic signed [WW:0]   wa, wb;
  logic                 take;

  assign ready = !v1 && !v2 && !v3 && !out_valid;
  assign take  = taps.valid && ready;

  always_comb begin
    wa       = $signed({1'b0, w_q});
    wb       = $signed({1'b0, WW'(OVERLAP_LEN) - w_q});
    num_next = a_q * wa + b_q * wb;
    mag_full = num[NW-1] ? NW'(-num) : NW'(num);
    q        = qprod[SHIFT +: SAMPLE_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      if (v3) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_q <= taps.tap_a;
      b_q <= taps.tap_b;
      w_q <= weight;
    end
    if (v1) begin
      num <= num_next;
    end
    if (v2) begin
      qprod <= PW'(mag_full[MW-1:0]) * PW'(RECIP);
      neg   <= num[NW-1];
    end
    if (v3) begin
      out_data <= neg ? (~q + 1'b1) : q;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

endmodule

`default_nettype wire

/* rtl/core/crossfade_delay_pitch_shifter.sv */
// Crossfade delay pitch shifter: usage.
// Samples arrive on din (valid / ready, signed 16-bit sample_in); each accepted
// sample yields exactly one pitch shifted sample on dout (signed sample_out).
// shift_ratio (unsigned Q2.8, 256 = no shift) is written through cfg_we /
// cfg_wdata; write it only while no sample is in flight.
// Pacing: the next input is taken only after the previous sample has passed the
// four-stage feedback of the high-pass filter plus one write and two tap reads
// on the single-port ring memory and its taps have gone to the mixer.
// Reset: synchronous, active high. Afterward the ring memory is cleared one
// entry per cycle, all BUF_DEPTH entries, with din.ready low; configuration
// writes are taken during that pass.
// Stall: a finished sample waits in the output register; the next input is
// still accepted and processed up to its memory reads, then holds until the
// output register has been drained.
// ============================================================================
// crossfade_delay_pitch_shifter
// Top level: high-pass input stage, ring delay with two crossfaded taps, mixer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "crossfade_delay_pitch_shifter_defines.svh"

module crossfade_delay_pitch_shifter import cdps_pkg::*; #(
  parameter int BUF_DEPTH   = 1000,
  parameter int OVERLAP_LEN = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RATIO_W-1:0] cfg_wdata,
  cdps_in_if.sink            din,
  cdps_out_if.source         dout
);

  localparam int WW = $clog2(OVERLAP_LEN + 1);

  logic [RATIO_W-1:0] shift_ratio;
  logic               in_take;
  logic               mix_ready;
  cdps_hp_res_t       hp_res;
  cdps_taps_t         taps;
  logic [WW-1:0]      weight;

  // Pitch ratio register; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_ratio <= RATIO_RESET;
    end else if (cfg_we) begin
      shift_ratio <= cfg_wdata;
    end
  end

  // An input transfer starts the filter and the sequencer together
  assign in_take = din.valid && din.ready;

  cdps_hpf u_hpf (
    .clk   (clk),
    .rst   (rst),
    .start (in_take),
    .x_in  (din.sample_in),
    .res   (hp_res)
  );

  // Ring memory, pointers and crossfade weight; advance once per sample
  cdps_ring #(
    .BUF_DEPTH   (BUF_DEPTH),
    .OVERLAP_LEN (OVERLAP_LEN)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .shift_ratio (shift_ratio),
    .in_valid    (din.valid),
    .in_ready    (din.ready),
    .hp_res      (hp_res),
    .mix_ready   (mix_ready),
    .taps        (taps),
    .weight      (weight)
  );

  // Mix the two taps and hold the result until the receiver takes it
  cdps_mix #(
    .OVERLAP_LEN (OVERLAP_LEN)
  ) u_mix (
    .clk    (clk),
    .rst    (rst),
    .taps   (taps),
    .weight (weight),
    .ready  (mix_ready),
    .dout   (dout)
  );

  // One sample in flight: no second input transfer right after one
  `CDPS_ASSERT_NXT(a_single_in_flight, in_take, !din.ready, "input taken twice in a row")
  // A filter result only appears while the sequencer is busy with its sample
  `CDPS_ASSERT_IMP(a_hp_res_busy, hp_res.valid, !din.ready, "filter result while idle")
  // A new output comes from a tap launch through the three mix stages
  `CDPS_ASSERT_IMP(a_out_from_launch, $rose(dout.valid), $past(taps.valid && mix_ready, 4), "output without launch")

endmodule

`default_nettype wire
